// File: hw/rtl/itra_pkg.sv
// Shared constants, types and the digit-to-ASCII mapping for the radix converter.
`timescale 1ns / 1ps
`default_nettype none
package itra_pkg;

	// Input and output field widths.
	localparam int VALUE_BITS = 31;
	localparam int RADIX_BITS = 5;
	localparam int CHAR_BITS  = 7;
	localparam int DIGIT_BITS = 4;

	// Divider step counter and digit stack sizing.
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int IDX_W = $clog2(VALUE_BITS);

	// Radix limits and the base that takes the optional prefix.
	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);
	localparam logic [RADIX_BITS-1:0] RADIX_HEX = RADIX_BITS'(16);

	// ASCII codes.
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] ASCII_UPPER = 7'h41;
	localparam logic [CHAR_BITS-1:0] ASCII_LOWER = 7'h61;
	localparam logic [CHAR_BITS-1:0] ASCII_X     = 7'h78;

	// Configuration register indexes.
	localparam logic CFG_LOWERCASE  = 1'b0;
	localparam logic CFG_HEX_PREFIX = 1'b1;

	// Request to the shared divider.
	typedef struct packed {
		logic                    start;
		logic [VALUE_BITS-1:0]   dividend;
		logic [RADIX_BITS-1:0]   divisor;
	} div_req_t;

	// Answer from the shared divider, valid while done is high.
	typedef struct packed {
		logic                    done;
		logic [VALUE_BITS-1:0]   quotient;
		logic [DIGIT_BITS-1:0]   remainder;
	} div_rsp_t;

	// Map a digit value to its ASCII character.
	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
		input logic lower);
		logic [CHAR_BITS-1:0] base;
		begin
			base = lower ? ASCII_LOWER : ASCII_UPPER;
			if (d < DIGIT_BITS'(10)) begin
				digit_char = ASCII_ZERO + CHAR_BITS'(d);
			end else begin
				digit_char = base + CHAR_BITS'(d) - CHAR_BITS'(10);
			end
		end
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/itra_divider.sv
// Restoring divider: one quotient bit per cycle, small divisor, narrow remainder.
`timescale 1ns / 1ps
`default_nettype none
module itra_divider (
	input  wire                clk,
	input  wire                arst_n,
	input  itra_pkg::div_req_t req,
	output itra_pkg::div_rsp_t rsp
);
	import itra_pkg::*;

	logic [VALUE_BITS-1:0] dvd_q;
	logic [DIGIT_BITS-1:0] rem_q;
	logic [RADIX_BITS-1:0] dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RADIX_BITS-1:0] shifted;
	logic                  fits;
	logic [RADIX_BITS-1:0] diff;

	// One trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, dvd_q[VALUE_BITS-1]};
		fits    = shifted >= dvs_q;
		diff    = shifted - dvs_q;
	end

	// Payload: dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? diff[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];
		end
	end

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CNT_W'(VALUE_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

// File: hw/rtl/itra_seq.sv
// Sequencer: drives the divider per digit, stacks the digits and emits characters.
`timescale 1ns / 1ps
`default_nettype none
module itra_seq (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [itra_pkg::VALUE_BITS-1:0]   in_value,
	input  wire  [itra_pkg::RADIX_BITS-1:0]   in_radix,
	input  wire                               lower,
	input  wire                               hex_prefix,
	output itra_pkg::div_req_t                div_req,
	input  itra_pkg::div_rsp_t                div_rsp,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [itra_pkg::CHAR_BITS-1:0]    out_char,
	output logic                              out_last
);
	import itra_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_PFX_ZERO,
		S_PFX_X,
		S_DIGITS,
		S_SINGLE
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [RADIX_BITS-1:0] radix_q;
	logic                  start_q;
	logic [CNT_W-1:0]      n_q;
	logic [DIGIT_BITS-1:0] stack_q [VALUE_BITS];
	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  out_char_q;
	logic                  out_last_q;
	logic                  accept;
	logic                  slot_free;
	logic                  special;
	logic [CNT_W-1:0]      top_idx;

	// Handshake and decoding of the incoming request.
	always_comb begin
		accept    = in_valid && (state_q == S_IDLE);
		slot_free = !out_valid_q || out_ready;
		special   = (in_value == '0) || (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
		top_idx   = n_q - CNT_W'(1);
	end

	// Digit stack: remainders pushed least significant first.
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && div_rsp.done) begin
			stack_q[n_q[IDX_W-1:0]] <= div_rsp.remainder;
		end
	end

	// Main state machine with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			val_q       <= '0;
			radix_q     <= '0;
			start_q     <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q   <= in_value;
						radix_q <= in_radix;
						n_q     <= '0;
						if (special) begin
							state_q <= S_SINGLE;
						end else begin
							state_q <= S_DIV;
							start_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						n_q <= n_q + CNT_W'(1);
						if (div_rsp.quotient == '0) begin
							if (radix_q == RADIX_HEX && hex_prefix) begin
								state_q <= S_PFX_ZERO;
							end else begin
								state_q <= S_DIGITS;
							end
						end else begin
							val_q   <= div_rsp.quotient;
							start_q <= 1'b1;
						end
					end
				end
				S_PFX_ZERO: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= ASCII_ZERO;
						out_last_q  <= 1'b0;
						state_q     <= S_PFX_X;
					end
				end
				S_PFX_X: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= ASCII_X;
						out_last_q  <= 1'b0;
						state_q     <= S_DIGITS;
					end
				end
				S_DIGITS: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= digit_char(stack_q[top_idx[IDX_W-1:0]], lower);
						out_last_q  <= (n_q == CNT_W'(1));
						n_q         <= top_idx;
						if (n_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SINGLE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= ASCII_ZERO;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign div_req.start    = start_q;
	assign div_req.dividend = val_q;
	assign div_req.divisor  = radix_q;
	assign out_valid        = out_valid_q;
	assign out_char         = out_char_q;
	assign out_last         = out_last_q;

endmodule
`default_nettype wire

// File: hw/rtl/integer_to_radix_ascii_top.sv
// Top level of the integer to radix ASCII converter: registers, sequencer and divider.
// Operation: each digit takes one pass of the shared divider; the characters then leave most
// significant first, after the 0x prefix for radix 16 when enabled; a special case answers with a single 0.
// Flow: one request at a time; the single shared divider retires one quotient bit per cycle.
// Reset: arst_n clears control state asynchronously; lowercase off, hex prefix on.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_radix_ascii_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [39:0] s_axis_tdata,  // [30:0] value, [35:31] radix, [39:36] zero
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [6:0] character, [7] zero
	output logic       m_axis_tlast,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire        cfg_data
);
	import itra_pkg::*;

	logic                 lower_q;
	logic                 hex_prefix_q;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [CHAR_BITS-1:0] out_char;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q      <= 1'b0;
			hex_prefix_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWERCASE:  lower_q      <= cfg_data;
				CFG_HEX_PREFIX: hex_prefix_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Digit sequencer.
	itra_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_value   (s_axis_tdata[VALUE_BITS-1:0]),
		.in_radix   (s_axis_tdata[VALUE_BITS+RADIX_BITS-1:VALUE_BITS]),
		.lower      (lower_q),
		.hex_prefix (hex_prefix_q),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_char   (out_char),
		.out_last   (m_axis_tlast)
	);

	// Shared divider.
	itra_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

// File: hw/rtl/itra_checker.sv
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module itra_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast
);

	// A request keeps the block busy for at least the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a request");

	// While ready for input, any pending character must close the previous string.
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && s_axis_tready |-> m_axis_tlast)
		else $error("non-final character pending while idle");

	// A stalled character stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// Characters are seven-bit ASCII.
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[7])
		else $error("pad bit set on output");

endmodule

bind integer_to_radix_ascii_top itra_checker u_itra_checker (.*);
`default_nettype wire

// File: test/integer_to_radix_ascii_top_tb.sv
// Testbench for the integer to radix ASCII converter: stream stimulus, digit prediction and checks.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_radix_ascii_top_tb;
	import itra_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int TAIL_CYCLES  = 40;
	localparam int PHASE_ITEMS  = 25;
	localparam int HOLD_CYCLES  = 500;

	// One expected output character.
	typedef struct {
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} ascii_char_t;

	// Digit predictor and store of the characters still to come.
	class ascii_scoreboard;
		logic          lower;
		logic          prefix;
		ascii_char_t   pending_chars[$];
		int            errors;
		int            requests;
		int            chars_seen;

		function new();
			lower      = 1'b0;
			prefix     = 1'b1;
			errors     = 0;
			requests   = 0;
			chars_seen = 0;
		endfunction

		function void set_register(input logic index, input logic data);
			if (index == CFG_LOWERCASE) begin
				lower = data;
			end else begin
				prefix = data;
			end
		endfunction

		function logic [CHAR_BITS-1:0] digit_to_ascii(input int unsigned d);
			if (d < 10) begin
				return ASCII_ZERO + CHAR_BITS'(d);
			end
			return (lower ? ASCII_LOWER : ASCII_UPPER) + CHAR_BITS'(d - 10);
		endfunction

		function void push_char(input logic [CHAR_BITS-1:0] code, input logic last);
			ascii_char_t c;
			c.code = code;
			c.last = last;
			pending_chars.push_back(c);
		endfunction

		// Work out the characters that one accepted request produces.
		function void note_request(input logic [VALUE_BITS-1:0] value,
			input logic [RADIX_BITS-1:0] radix);
			logic [CHAR_BITS-1:0] digits[$];
			logic [VALUE_BITS-1:0] rest;
			int unsigned           base;
			requests++;
			base = 32'(radix);
			if (value == '0 || base < 2 || base > 16) begin
				push_char(ASCII_ZERO, 1'b1);
				return;
			end
			rest = value;
			while (rest != '0) begin
				digits.push_front(digit_to_ascii(rest % base));
				rest = VALUE_BITS'(rest / base);
			end
			if (base == 16 && prefix) begin
				push_char(ASCII_ZERO, 1'b0);
				push_char(ASCII_X, 1'b0);
			end
			foreach (digits[i]) begin
				push_char(digits[i], i == digits.size() - 1);
			end
		endfunction

		// Compare one accepted character with the oldest expectation.
		function void check_char(input logic [CHAR_BITS-1:0] code, input logic last);
			ascii_char_t e;
			chars_seen++;
			if (pending_chars.size() == 0) begin
				$error("unexpected character: character=%h last=%b", code, last);
				errors++;
				return;
			end
			e = pending_chars.pop_front();
			if (code !== e.code) begin
				$error("character mismatch: expected %h, actual %h", e.code, code);
				errors++;
			end
			if (last !== e.last) begin
				$error("last mismatch: expected %b, actual %b", e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata  = '0;  // [30:0] value, [35:31] radix, [39:36] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [6:0] character, [7] zero
	logic        m_axis_tlast;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic        cfg_data      = 1'b0;

	ascii_scoreboard sb = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold   = 0;

	integer_to_radix_ascii_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Offer one request, with random idle cycles ahead of it unless tx_steady is set, and wait until it is taken.
	task automatic send_request(input logic [VALUE_BITS-1:0] value,
		input logic [RADIX_BITS-1:0] radix);
		while (!tx_steady && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, radix, value};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(value, radix);
	endtask

	// Stop offering and wait until every predicted character has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; only called while the block is idle.
	task automatic write_config(input logic lower, input logic prefix);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOWERCASE;
		cfg_data  <= lower;
		@(posedge clk);
		cfg_index <= CFG_HEX_PREFIX;
		cfg_data  <= prefix;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_register(CFG_LOWERCASE, lower);
		sb.set_register(CFG_HEX_PREFIX, prefix);
	endtask

	// Random request: magnitude spread by a random shift, mostly valid radixes.
	task automatic send_random();
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0] radix;
		value = VALUE_BITS'($urandom >> $urandom_range(1, 31));
		if ($urandom_range(99) < 12) begin
			radix = RADIX_BITS'($urandom);
		end else begin
			radix = RADIX_BITS'($urandom_range(2, 16));
		end
		send_request(value, radix);
	endtask

	// Output side: check each accepted character, then choose the next ready level.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_char(m_axis_tdata[CHAR_BITS-1:0], m_axis_tlast);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= rx_steady || ($urandom_range(99) >= 23);
			end
		end
	end

	// Main sequence: directed corner cases, then random phases under each register setting.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero values, full-scale values, degenerate radixes and letter digits.
		send_request('0, 5'd10);
		send_request('0, RADIX_HEX);
		send_request('0, 5'd2);
		send_request({VALUE_BITS{1'b1}}, 5'd2);
		send_request({VALUE_BITS{1'b1}}, RADIX_HEX);
		send_request({VALUE_BITS{1'b1}}, 5'd10);
		send_request({VALUE_BITS{1'b1}}, 5'd3);
		send_request(VALUE_BITS'(1), 5'd2);
		send_request(VALUE_BITS'(12345), 5'd0);
		send_request(VALUE_BITS'(12345), 5'd1);
		send_request(VALUE_BITS'(12345), 5'd17);
		send_request(VALUE_BITS'(32'h2AAAAAAA), 5'd31);
		send_request(VALUE_BITS'(32'h15555555), 5'd8);
		send_request(VALUE_BITS'(255), RADIX_HEX);
		send_request(VALUE_BITS'(15), RADIX_HEX);
		send_request(VALUE_BITS'(14), 5'd15);
		send_request(VALUE_BITS'(16), RADIX_HEX);
		send_request(VALUE_BITS'(8), 5'd8);
		send_request(VALUE_BITS'(32'h00ABCDEF), RADIX_HEX);
		send_request(VALUE_BITS'(999), 5'd10);
		send_request(VALUE_BITS'(1), RADIX_HEX);
		wait_drained();

		// Lowercase letters with the prefix kept.
		write_config(1'b1, 1'b1);
		repeat (PHASE_ITEMS) send_random();
		wait_drained();

		// Prefix off; the receiver holds off while short requests keep coming.
		write_config(1'b0, 1'b0);
		rx_hold   = HOLD_CYCLES;
		tx_steady = 1'b1;
		repeat (8) send_request(VALUE_BITS'($urandom_range(0, 9999)), 5'd10);
		tx_steady = 1'b0;
		repeat (PHASE_ITEMS - 8) send_random();
		wait_drained();

		// Lowercase without prefix, both sides running without gaps.
		write_config(1'b1, 1'b0);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (PHASE_ITEMS) send_random();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_drained();

		// Back to the reset setting.
		write_config(1'b0, 1'b1);
		repeat (PHASE_ITEMS) send_random();
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Converted %0d requests into %0d characters in radixes 0 to 31,",
			sb.requests, sb.chars_seen);
		$display("under all four letter-case and prefix settings, with stalls on both sides.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			if (sb.pending() != 0) begin
				$error("%0d expected characters never arrived", sb.pending());
			end
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
